[sv/ade_pkg.sv]
// Package for the array deque engine: request codes, status codes and word types.
`timescale 1ns / 1ps

package ade_pkg;

  // Default sizing of the element store.
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the word fields.
  localparam int unsigned REQ_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned CNT_W = 11;

  // Request codes. The code left over is treated as a no-op.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Input word.
  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] data_in;
  } ade_req_t;

  // Result word.
  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        item_count;
    logic                    empty_flag;
  } ade_res_t;

  // Registered result control handed from the controller to the output stage.
  typedef struct packed {
    logic             valid;
    logic             take_rd;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] item_count;
    logic             empty_flag;
  } ade_ctl_t;

endpackage

[sv/ade_store.sv]
// Element store of the array deque engine: one synchronous single-port memory.
`timescale 1ns / 1ps

module ade_store
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // A request either writes or reads, never both, so there is no
  // same-cycle collision to resolve.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/ade_ctrl.sv]
// Index keeper of the array deque engine: decodes requests, drives the store, registers status.
`timescale 1ns / 1ps

module ade_ctrl
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned IDX_W     = AW + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ade_req_t              req_i,
  output logic                  we_o,
  output logic                  re_o,
  output logic [AW-1:0]         addr_o,
  output logic [DATA_WIDTH-1:0] wdata_o,
  output ade_ctl_t              ctl_o
);

  localparam logic [IDX_W-1:0] HALF = IDX_W'(DEPTH / 2);
  localparam logic [IDX_W-1:0] TOP  = IDX_W'(DEPTH);

  // The front index points at the first element and the rear index one past the
  // last, so the live run is [front_q, rear_q) and the element count is rear_q - front_q.
  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] rear_q, rear_d;
  logic [IDX_W-1:0] cnt_now, cnt_next;
  logic             empty_now;
  logic [IDX_W-1:0] addr_full;
  status_e          status;
  logic             take_rd;
  logic [63:0]      data_wide;
  ade_ctl_t         ctl_q, ctl_d;

  assign cnt_now   = rear_q - front_q;
  assign empty_now = (cnt_now == '0);
  assign data_wide = 64'($unsigned(req_i.data_in));
  assign wdata_o   = data_wide[DATA_WIDTH-1:0];

  always_comb begin
    front_d   = front_q;
    rear_d    = rear_q;
    we_o      = 1'b0;
    re_o      = 1'b0;
    addr_full = '0;
    status    = ST_OK;
    take_rd   = 1'b0;
    if (accept_i) begin
      unique case (req_e'(req_i.req_type))
        REQ_PUSH_FRONT: begin
          if (front_q == '0) begin
            status = ST_FULL;
          end else begin
            we_o      = 1'b1;
            addr_full = front_q - 1'b1;
            front_d   = front_q - 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          if (rear_q == TOP) begin
            status = ST_FULL;
          end else begin
            we_o      = 1'b1;
            addr_full = rear_q;
            rear_d    = rear_q + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          if (empty_now) begin
            status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            take_rd   = 1'b1;
            addr_full = front_q;
            front_d   = front_q + 1'b1;
          end
        end
        REQ_POP_BACK: begin
          if (empty_now) begin
            status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            take_rd   = 1'b1;
            addr_full = rear_q - 1'b1;
            rear_d    = rear_q - 1'b1;
          end
        end
        REQ_PEEK_FRONT: begin
          if (empty_now) begin
            status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            take_rd   = 1'b1;
            addr_full = front_q;
          end
        end
        REQ_PEEK_BACK: begin
          if (empty_now) begin
            status = ST_EMPTY;
          end else begin
            re_o      = 1'b1;
            take_rd   = 1'b1;
            addr_full = rear_q - 1'b1;
          end
        end
        REQ_CLEAR: begin
          front_d = HALF;
          rear_d  = HALF;
        end
        default: begin
        end
      endcase
    end
  end

  assign addr_o   = addr_full[AW-1:0];
  assign cnt_next = rear_d - front_d;

  always_comb begin
    ctl_d            = ctl_q;
    ctl_d.valid      = accept_i;
    if (accept_i) begin
      ctl_d.take_rd    = take_rd;
      ctl_d.status     = status;
      ctl_d.item_count = CNT_W'(cnt_next);
      ctl_d.empty_flag = (cnt_next == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= HALF;
      rear_q  <= HALF;
      ctl_q   <= '0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      ctl_q   <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;

endmodule

[sv/array_deque_engine.sv]
// Top level of the array deque engine: controller, element store and result stage.
`timescale 1ns / 1ps

// Channel   Ports                    Direction  Handshake
// request   start, busy, req_i       in         taken when start is high and busy is low
// result    done_o, res_o            out        one cycle on done_o, cannot be held off
//
// Every request word gives exactly one result word, in the cycle after it is
// taken: the store read issued in the accept cycle returns in the next one.
// A new request can be taken in every cycle; busy stays low because the
// indices are updated in the accept cycle and each request touches at most one
// store entry through the single memory port. Reset returns both indices
// to the middle of the store; the store itself is not cleared, since only
// entries inside the live run are ever read.

module array_deque_engine
  import ade_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  ade_req_t req_i,
  output logic     done_o,
  output ade_res_t res_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                  accept;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic [63:0]           rd_wide;
  ade_ctl_t              ctl;

  // The engine never has to hold a request back.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ade_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .we_o     (mem_we),
    .re_o     (mem_re),
    .addr_o   (mem_addr),
    .wdata_o  (mem_wdata),
    .ctl_o    (ctl)
  );

  ade_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Stored elements are zero-extended or truncated to the 32-bit read value;
  // requests that read nothing report zero.
  assign rd_wide = 64'(mem_rdata);

  always_comb begin
    res_o.read_value = ctl.take_rd ? $signed(rd_wide[VAL_W-1:0]) : '0;
    res_o.status     = ctl.status;
    res_o.item_count = ctl.item_count;
    res_o.empty_flag = ctl.empty_flag;
  end

  assign done_o = ctl.valid;

endmodule
